### design/spc_pkg.sv
package spc_pkg;

   localparam int FRAC_BITS  = 20;
   localparam int SPEED_W    = 16;
   localparam int RPM_W      = 11;
   localparam int GAIN_W     = 24;
   localparam int TARGET_W   = 12;
   localparam int ERR_W      = 13;
   localparam int DELTA_W    = 14;
   localparam int INTEG_W    = 32;
   localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W   = GAIN_W + 1 + INTEG_W;
   localparam int PROD_D_W   = GAIN_W + 1 + DELTA_W;
   localparam int DRIVE_W    = 59;
   localparam int TOTAL_W    = 60;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0]   KP_RESET     = 24'd104858;
   localparam logic [GAIN_W-1:0]   KI_RESET     = 24'd524;
   localparam logic [GAIN_W-1:0]   KD_RESET     = 24'd0;
   localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd220;

   // rpm = count * 60 / 2048
   localparam int RPM_MUL   = 60;
   localparam int RPM_SHIFT = 11;

   typedef enum logic [1:0] {
      REG_KP     = 2'd0,
      REG_KI     = 2'd1,
      REG_KD     = 2'd2,
      REG_TARGET = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gain_set_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [DELTA_W-1:0] delta;
      logic signed [INTEG_W-1:0] integ;
      logic [RPM_W-1:0]          rpm;
   } err_stage_type;

   typedef struct packed {
      logic signed [PROD_P_W-1:0] p_term;
      logic signed [PROD_I_W-1:0] i_term;
      logic signed [PROD_D_W-1:0] d_term;
      logic [RPM_W-1:0]           rpm;
   } prod_stage_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic [RPM_W-1:0]          rpm;
   } drive_stage_type;

endpackage

### design/spc_csr.sv
module spc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [spc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [spc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [spc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output spc_pkg::gain_set_type            gains,
   output logic [spc_pkg::TARGET_W-1:0]     target_rpm
);
   import spc_pkg::*;

   logic [GAIN_W-1:0]   kp_ff;
   logic [GAIN_W-1:0]   ki_ff;
   logic [GAIN_W-1:0]   kd_ff;
   logic [TARGET_W-1:0] target_ff;
   logic                wr_en;
   reg_index_type       index;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= KP_RESET;
         ki_ff     <= KI_RESET;
         kd_ff     <= KD_RESET;
         target_ff <= TARGET_RESET;
      end else if (wr_en) begin
         unique case (index)
            REG_KP:     kp_ff     <= csr_pwdata[GAIN_W-1:0];
            REG_KI:     ki_ff     <= csr_pwdata[GAIN_W-1:0];
            REG_KD:     kd_ff     <= csr_pwdata[GAIN_W-1:0];
            REG_TARGET: target_ff <= csr_pwdata[TARGET_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_KP:     csr_prdata = CSR_DATA_W'(kp_ff);
         REG_KI:     csr_prdata = CSR_DATA_W'(ki_ff);
         REG_KD:     csr_prdata = CSR_DATA_W'(kd_ff);
         REG_TARGET: csr_prdata = CSR_DATA_W'(target_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign gains.kp   = kp_ff;
   assign gains.ki   = ki_ff;
   assign gains.kd   = kd_ff;
   assign target_rpm = target_ff;

endmodule

### design/spc_error.sv
module spc_error (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [spc_pkg::SPEED_W-1:0]   speed,
   input  logic [spc_pkg::TARGET_W-1:0]  target_rpm,
   output logic                          out_valid,
   input  logic                          out_ready,
   output spc_pkg::err_stage_type        out_stage
);
   import spc_pkg::*;

   localparam int MUL_W = SPEED_W + 6;

   logic                        valid_ff;
   err_stage_type               stage_ff;
   err_stage_type               stage_in;
   logic signed [INTEG_W-1:0]   integ_ff;
   logic signed [INTEG_W-1:0]   integ_in;
   logic signed [ERR_W-1:0]     last_err_ff;
   logic [MUL_W-1:0]            scaled;
   logic [RPM_W-1:0]            rpm;
   logic signed [ERR_W-1:0]     err;
   logic signed [INTEG_W:0]     integ_sum;
   logic                        take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      scaled    = MUL_W'(speed) * MUL_W'(RPM_MUL);
      rpm       = scaled[RPM_SHIFT +: RPM_W];
      err       = $signed({2'b00, rpm}) - $signed({1'b0, target_rpm});
      integ_sum = {integ_ff[INTEG_W-1], integ_ff} + (INTEG_W+1)'(err);
      // saturate when the two top bits disagree
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
      stage_in.err   = err;
      stage_in.delta = DELTA_W'(err) - DELTA_W'(last_err_ff);
      stage_in.integ = integ_ff;
      stage_in.rpm   = rpm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            integ_ff    <= integ_in;
            last_err_ff <= err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

### design/spc_mac.sv
module spc_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  spc_pkg::gain_set_type         gains,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  spc_pkg::err_stage_type        in_stage,
   output logic                          out_valid,
   input  logic                          out_ready,
   output spc_pkg::drive_stage_type      out_stage
);
   import spc_pkg::*;

   logic             prod_valid_ff;
   logic             drive_valid_ff;
   logic             prod_ready;
   prod_stage_type   prod_ff;
   prod_stage_type   prod_in;
   drive_stage_type  drive_ff;
   drive_stage_type  drive_in;

   assign prod_ready = !drive_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || prod_ready;

   // unsigned gains times signed operands
   always_comb begin
      prod_in.p_term = $signed({1'b0, gains.kp}) * in_stage.err;
      prod_in.i_term = $signed({1'b0, gains.ki}) * in_stage.integ;
      prod_in.d_term = $signed({1'b0, gains.kd}) * in_stage.delta;
      prod_in.rpm    = in_stage.rpm;
   end

   always_comb begin
      drive_in.drive = DRIVE_W'(prod_ff.p_term) + DRIVE_W'(prod_ff.i_term)
                     + DRIVE_W'(prod_ff.d_term);
      drive_in.rpm   = prod_ff.rpm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff  <= 1'b0;
         drive_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (prod_ready) begin
            drive_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
      if (prod_valid_ff && prod_ready) begin
         drive_ff <= drive_in;
      end
   end

   assign out_valid = drive_valid_ff;
   assign out_stage = drive_ff;

endmodule

### design/spc_compare.sv
module spc_compare #(
   parameter int COMPARE_MAX = 999
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  spc_pkg::drive_stage_type               in_stage,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [$clog2(COMPARE_MAX+1)-1:0]       compare_value,
   output logic [spc_pkg::RPM_W-1:0]              measured_rpm
);
   import spc_pkg::*;

   localparam int CMP_W = $clog2(COMPARE_MAX + 1);
   localparam logic signed [TOTAL_W-1:0] TOP = TOTAL_W'(COMPARE_MAX) << FRAC_BITS;
   localparam logic signed [TOTAL_W-1:0] ONE = TOTAL_W'(1) << FRAC_BITS;

   logic                        valid_ff;
   logic [CMP_W-1:0]            compare_ff;
   logic [CMP_W-1:0]            compare_in;
   logic [RPM_W-1:0]            rpm_ff;
   logic signed [TOTAL_W-1:0]   total;
   logic                        take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      total = $signed({{(TOTAL_W-CMP_W-FRAC_BITS){1'b0}}, compare_ff, {FRAC_BITS{1'b0}}})
            + TOTAL_W'(in_stage.drive);
      priority if (total >= TOP) begin
         compare_in = CMP_W'(COMPARE_MAX);
      end else if (total < ONE) begin
         compare_in = '0;
      end else begin
         compare_in = total[FRAC_BITS +: CMP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         compare_ff <= CMP_W'(COMPARE_MAX);
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            compare_ff <= compare_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rpm_ff <= in_stage.rpm;
      end
   end

   assign out_valid     = valid_ff;
   assign compare_value = compare_ff;
   assign measured_rpm  = rpm_ff;

endmodule

### design/speed_pid_pwm_compare.sv
// a transaction accepted on req passes, in order, the input register, error stage,
// product stage, drive sum and compare register; compare_ff feeds its own update
// throughput: one transaction per cycle unless rsp_tready stalls the pipeline
// reset: synchronous, clears integral and previous error, loads the compare
// value with COMPARE_MAX and the registers with their default gains and set point
module speed_pid_pwm_compare #(
   parameter int COMPARE_MAX = 999
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,   // speed_count
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // compare_value, measured_rpm, zero padding
   output logic [((($clog2(COMPARE_MAX+1)+spc_pkg::RPM_W)+7)/8)*8-1:0] rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [spc_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [spc_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [spc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import spc_pkg::*;

   localparam int CMP_W  = $clog2(COMPARE_MAX + 1);
   localparam int DATA_W = ((CMP_W + RPM_W + 7) / 8) * 8;

   gain_set_type        gains;
   logic [TARGET_W-1:0] target_rpm;

   logic                speed_valid_ff;
   logic [SPEED_W-1:0]  speed_ff;
   logic                err_ready;
   logic                err_valid;
   err_stage_type       err_stage;
   logic                mac_ready;
   logic                drive_valid;
   drive_stage_type     drive_stage;
   logic                cmp_ready;
   logic [CMP_W-1:0]    compare_value;
   logic [RPM_W-1:0]    measured_rpm;

   spc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains),
      .target_rpm  (target_rpm)
   );

   // input register
   assign req_tready = !speed_valid_ff || err_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_valid_ff <= 1'b0;
      end else if (req_tready) begin
         speed_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         speed_ff <= req_tdata;
      end
   end

   spc_error u_error (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (speed_valid_ff),
      .in_ready   (err_ready),
      .speed      (speed_ff),
      .target_rpm (target_rpm),
      .out_valid  (err_valid),
      .out_ready  (mac_ready),
      .out_stage  (err_stage)
   );

   spc_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains),
      .in_valid  (err_valid),
      .in_ready  (mac_ready),
      .in_stage  (err_stage),
      .out_valid (drive_valid),
      .out_ready (cmp_ready),
      .out_stage (drive_stage)
   );

   spc_compare #(
      .COMPARE_MAX (COMPARE_MAX)
   ) u_compare (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (drive_valid),
      .in_ready      (cmp_ready),
      .in_stage      (drive_stage),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .compare_value (compare_value),
      .measured_rpm  (measured_rpm)
   );

   assign rsp_tdata = DATA_W'({measured_rpm, compare_value});

   a_compare_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(compare_value) <= COMPARE_MAX))
      else $error("compare value above COMPARE_MAX");

   a_rpm_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (measured_rpm <= 11'd1919))
      else $error("measured rpm out of range");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

endmodule

### tb/tb_speed_pid_pwm_compare.sv
`timescale 1ns / 100ps

module tb_speed_pid_pwm_compare;
   import spc_pkg::*;

   localparam int CMP_MAX        = 999;
   localparam int CMP_W          = $clog2(CMP_MAX + 1);
   localparam int RSP_W          = ((CMP_W + RPM_W + 7) / 8) * 8;
   localparam int RESULT_LATENCY = 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_TICKS    = 20;
   localparam logic [GAIN_W-1:0] GAIN_TOP = '1;
   localparam logic [TARGET_W-1:0] TARGET_TOP = '1;

   typedef struct {
      logic [CMP_W-1:0] compare_value;
      logic [RPM_W-1:0] measured_rpm;
   } pwm_update_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SPEED_W-1:0]    req_tdata = '0;     // speed_count
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;          // compare_value, measured_rpm, zero padding
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   speed_pid_pwm_compare #(
      .COMPARE_MAX(CMP_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // controller shadow state
   logic [GAIN_W-1:0]   kp_shadow = KP_RESET;
   logic [GAIN_W-1:0]   ki_shadow = KI_RESET;
   logic [GAIN_W-1:0]   kd_shadow = KD_RESET;
   logic [TARGET_W-1:0] target_shadow = TARGET_RESET;
   int                  integral_acc = 0;
   int                  held_error = 0;
   int                  pwm_compare = CMP_MAX;

   logic [SPEED_W-1:0] speed_counts[$];
   pwm_update_type     expected_updates[$];

   int  pushed_total = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  error_count = 0;
   int  csr_writes = 0;
   int  ceiling_hits = 0;
   int  floor_hits = 0;
   int  integral_sat_ticks = 0;
   int  idle_cycles = 0;
   bit  idle_on = 1'b1;
   bit  stall_on = 1'b1;
   int  send_gap = 0;
   int  hold_left = 0;

   function automatic pwm_update_type advance_speed_loop(logic [SPEED_W-1:0] count);
      int unsigned    scaled;
      int             rpm;
      int             err;
      longint         drive;
      longint         acc;
      longint         total;
      longint         one;
      pwm_update_type upd;
      scaled = 32'(count) * 60;
      rpm = int'(scaled >> 11);
      err = rpm - int'({20'd0, target_shadow});
      drive = longint'({40'd0, kp_shadow}) * longint'(err)
            + longint'({40'd0, ki_shadow}) * longint'(integral_acc)
            + longint'({40'd0, kd_shadow}) * (longint'(err) - longint'(held_error));
      acc = longint'(integral_acc) + longint'(err);
      if (acc > 64'sd2147483647) begin
         acc = 64'sd2147483647;
         integral_sat_ticks++;
      end else if (acc < -64'sd2147483648) begin
         acc = -64'sd2147483648;
         integral_sat_ticks++;
      end
      integral_acc = int'(acc);
      held_error = err;
      one = 64'sd1 <<< FRAC_BITS;
      total = longint'(pwm_compare) * one + drive;
      if (total >= longint'(CMP_MAX) * one)
         pwm_compare = CMP_MAX;
      else if (total < one)
         pwm_compare = 0;
      else
         pwm_compare = int'(total >>> FRAC_BITS);
      upd.compare_value = CMP_W'(pwm_compare);
      upd.measured_rpm = RPM_W'(rpm);
      return upd;
   endfunction

   // speed count driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 5);
            req_tvalid <= 1'b0;
         end else if (speed_counts.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= speed_counts.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
         hold_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: check the result transaction first, then predict the new one
   always @(posedge clock) begin
      pwm_update_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_updates.size() == 0) begin
               $error("unexpected result transaction, rsp_tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_updates.pop_front();
               if (rsp_tdata[CMP_W-1:0] !== want.compare_value) begin
                  $error("compare_value: expected %0d, got %0d",
                         want.compare_value, rsp_tdata[CMP_W-1:0]);
                  error_count++;
               end
               if (rsp_tdata[CMP_W +: RPM_W] !== want.measured_rpm) begin
                  $error("measured_rpm: expected %0d, got %0d",
                         want.measured_rpm, rsp_tdata[CMP_W +: RPM_W]);
                  error_count++;
               end
               if (want.compare_value == CMP_W'(CMP_MAX))
                  ceiling_hits++;
               if (want.compare_value == '0)
                  floor_hits++;
               results_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_updates.push_back(advance_speed_loop(req_tdata));
            items_sent++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("speed_pid_pwm_compare regression: fail");
            $finish;
         end
      end
   end

   // write one register, then read it back
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] kept;
      kept = (idx == REG_TARGET) ? (value & CSR_DATA_W'(TARGET_TOP))
                                 : (value & CSR_DATA_W'(GAIN_TOP));
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_KP:     kp_shadow = kept[GAIN_W-1:0];
         REG_KI:     ki_shadow = kept[GAIN_W-1:0];
         REG_KD:     kd_shadow = kept[GAIN_W-1:0];
         REG_TARGET: target_shadow = kept[TARGET_W-1:0];
         default: ;
      endcase
      csr_writes++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== kept) begin
         $error("csr_prdata: expected %h, got %h", kept, csr_prdata);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // upper bits carry junk so that the width masking is exercised
   task automatic set_loop_tuning(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                  input logic [GAIN_W-1:0] kd,
                                  input logic [TARGET_W-1:0] target);
      csr_write(REG_KP, {8'($urandom), kp});
      csr_write(REG_KI, {8'($urandom), ki});
      csr_write(REG_KD, {8'($urandom), kd});
      csr_write(REG_TARGET, {20'($urandom), target});
   endtask

   task automatic queue_speed(input logic [SPEED_W-1:0] count);
      speed_counts.push_back(count);
      pushed_total++;
   endtask

   // wait until every queued count is sent and every expected result is back
   task automatic settle();
      while (items_sent != pushed_total || expected_updates.size() != 0)
         @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain(input int style);
      case (style)
         0: return '0;
         1: return GAIN_TOP;
         2: return GAIN_W'($urandom);
         default: return GAIN_W'($urandom_range(0, 1 << 18));
      endcase
   endfunction

   function automatic logic [SPEED_W-1:0] pick_speed(input logic [TARGET_W-1:0] target);
      int centre;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         // around the set point so the loop actually regulates
         centre = (int'(target) * 2048) / 60 + $urandom_range(0, 400) - 200;
         if (centre < 0)
            centre = 0;
         if (centre > 65535)
            centre = 65535;
         return SPEED_W'(centre);
      end else if (pick < 9) begin
         return SPEED_W'($urandom);
      end else begin
         return ($urandom_range(0, 1) == 0) ? '0 : '1;
      end
   endfunction

   initial begin
      logic [GAIN_W-1:0]   kp;
      logic [GAIN_W-1:0]   ki;
      logic [GAIN_W-1:0]   kd;
      logic [TARGET_W-1:0] target;
      int                  style;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset tuning: rpm truncation edges, single-bit and alternating bit patterns
      queue_speed(16'd0);
      queue_speed(16'hFFFF);
      queue_speed(16'd7509);
      queue_speed(16'd7510);
      queue_speed(16'd7511);
      queue_speed(16'd1);
      queue_speed(16'd34);
      queue_speed(16'd35);
      queue_speed(16'h8000);
      queue_speed(16'h5555);
      queue_speed(16'hAAAA);
      queue_speed(16'd2048);
      settle();

      // drive below range
      set_loop_tuning(GAIN_TOP, '0, GAIN_TOP, TARGET_TOP);
      queue_speed(16'd0);
      queue_speed(16'hFFFF);
      queue_speed(16'd0);
      settle();

      // drive above range
      set_loop_tuning(GAIN_TOP, GAIN_TOP, '0, '0);
      queue_speed(16'hFFFF);
      queue_speed(16'hFFFF);
      queue_speed(16'd0);
      settle();

      set_loop_tuning('0, '0, '0, 12'd1919);
      queue_speed(16'hFFFF);
      queue_speed(16'd0);
      settle();

      for (int phase = 0; phase < 12; phase++) begin
         if (phase >= 9) begin
            idle_on = 1'b0;
            stall_on = 1'b0;
         end
         style = phase % 4;
         if (style == 1) begin
            kp = pick_gain($urandom_range(0, 2));
            ki = pick_gain($urandom_range(0, 2));
            kd = pick_gain($urandom_range(0, 2));
            case ($urandom_range(0, 2))
               0: target = '0;
               1: target = TARGET_TOP;
               default: target = TARGET_W'($urandom);
            endcase
         end else if (style == 3) begin
            kp = GAIN_W'($urandom_range(0, 1 << 15));
            ki = GAIN_W'($urandom_range(0, 1 << 9));
            kd = GAIN_W'($urandom_range(0, 1 << 15));
            target = TARGET_W'($urandom_range(0, 1919));
         end else begin
            kp = pick_gain(3);
            ki = GAIN_W'($urandom_range(0, 1 << 12));
            kd = pick_gain(3);
            target = TARGET_W'($urandom_range(0, 1919));
         end
         set_loop_tuning(kp, ki, kd, target);
         for (int n = 0; n < 75; n++)
            queue_speed(pick_speed(target));
         settle();
      end

      // largest negative error winds the integral down
      set_loop_tuning('0, '0, '0, TARGET_TOP);
      for (int n = 0; n < DRAIN_TICKS; n++)
         queue_speed(16'd0);
      settle();
      set_loop_tuning(GAIN_W'(1 << 16), GAIN_W'(1 << 10), GAIN_W'(1 << 14), '0);
      for (int n = 0; n < 20; n++)
         queue_speed(SPEED_W'($urandom));
      settle();

      repeat (20) @(posedge clock);
      if (expected_updates.size() != 0) begin
         $error("%0d expected results never arrived", expected_updates.size());
         error_count++;
      end
      $display("%0d speed counts sent, %0d results checked, %0d register writes",
               items_sent, results_checked, csr_writes);
      $display("compare at ceiling %0d times, at floor %0d times, integral saturated %0d ticks",
               ceiling_hits, floor_hits, integral_sat_ticks);
      if (error_count == 0) begin
         $display("speed_pid_pwm_compare regression: pass");
      end else begin
         $display("speed_pid_pwm_compare regression: fail");
      end
      $finish;
   end

endmodule
